// ===== hdl/gzd_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// gzd_pkg
// Shared constants, result word type and a helper for the gzip/zlib header
// detector.
// ============================================================================
package gzd_pkg;

    localparam int LEN_W = 32;

    localparam logic [1:0] FMT_RAW  = 2'd0;
    localparam logic [1:0] FMT_ZLIB = 2'd1;
    localparam logic [1:0] FMT_GZIP = 2'd2;

    localparam logic [7:0] GZ_ID1    = 8'h1F;
    localparam logic [7:0] GZ_ID2    = 8'h8B;
    localparam logic [7:0] GZ_CM     = 8'h08;
    localparam logic [7:0] FLG_FHCRC = 8'h02;
    localparam logic [7:0] FLG_FEXTRA = 8'h04;
    localparam logic [7:0] FLG_FNAME = 8'h08;
    localparam logic [7:0] FLG_FCMT  = 8'h10;
    localparam logic [3:0] ZLIB_CM   = 4'h8;

    localparam logic [LEN_W-1:0] GZ_MIN_LEN  = LEN_W'(10);
    localparam logic [LEN_W-1:0] GZ_HDR_LAST = LEN_W'(9);
    localparam logic [LEN_W-1:0] GZ_FLG_POS  = LEN_W'(3);
    localparam logic [LEN_W-1:0] TRAILER_LEN = LEN_W'(8);
    localparam logic [15:0]      HCRC_LEN    = 16'd2;

    localparam int RES_MAX = 3;

    typedef struct packed {
        logic [7:0]       data;
        logic             valid;
        logic [1:0]       fmt;
        logic [LEN_W-1:0] plen;
        logic             err;
        logic             last;
    } res_t;

    // True when the 16-bit value is a multiple of 31, by folding 5-bit digits.
    function automatic logic mod31_zero(input logic [15:0] v);
        logic [6:0] s1;
        logic [5:0] s2;
        s1 = {2'b00, v[4:0]} + {2'b00, v[9:5]} + {2'b00, v[14:10]} + {6'd0, v[15]};
        s2 = {1'b0, s1[4:0]} + {4'd0, s1[6:5]};
        return (s2 == 6'd0) || (s2 == 6'd31);
    endfunction

endpackage

// ===== hdl/gzip_zlib_header_detector.sv =====
`timescale 1ns / 1ps
// ============================================================================
// gzip_zlib_header_detector
// Classifies a compressed file as gzip, zlib or raw deflate and forwards the
// deflate stream bytes.
//
// The block takes one byte per cycle while in_ready is high. Each byte is
// decided in the cycle it is accepted and its result words go into a
// four-word result queue; the third byte of a file can release up to three
// words (the two held bytes and itself), and the last byte of a two-byte
// file releases two, so in_ready is high while the queue holds at most one
// word. A byte that releases two or three words at once therefore stalls the
// input while the queue drains, even with res_ready high. The file length is
// written on the cfg channel and resets to one; the user must write it only
// between files, which the block itself does not enforce.
// ============================================================================
module gzip_zlib_header_detector
    import gzd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [LEN_W-1:0]  cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        in_byte,
    input  logic              in_last,
    output logic              res_valid,
    input  logic              res_ready,
    output logic [7:0]        out_byte,
    output logic              out_valid,
    output logic [1:0]        format,
    output logic [LEN_W-1:0]  payload_length,
    output logic              header_error,
    output logic              out_last
);

    res_t [RES_MAX-1:0] res;
    logic [1:0]         res_cnt;
    logic               acc;
    logic               pop;
    res_t               mem_reg [4];
    logic [1:0]         wr_ptr_reg, wr_ptr_next;
    logic [1:0]         rd_ptr_reg, rd_ptr_next;
    logic [2:0]         count_reg, count_next;
    res_t               head;

    assign cfg_ready = 1'b1;
    assign in_ready  = (count_reg <= 3'd1);
    assign acc       = in_valid && in_ready;
    assign res_valid = (count_reg != 3'd0);
    assign pop       = res_valid && res_ready;

    gzd_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .acc     (acc),
        .in_byte (in_byte),
        .in_last (in_last),
        .cfg_we  (cfg_valid && cfg_ready),
        .cfg_data(cfg_data),
        .res     (res),
        .res_cnt (res_cnt)
    );

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + res_cnt;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + {1'b0, res_cnt} - {2'b00, pop};
        head        = mem_reg[rd_ptr_reg];
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < RES_MAX; i++)
        begin
            if (2'(i) < res_cnt)
            begin
                mem_reg[wr_ptr_reg + 2'(i)] <= res[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign out_byte       = head.data;
    assign out_valid      = head.valid;
    assign format         = head.fmt;
    assign payload_length = head.plen;
    assign header_error   = head.err;
    assign out_last       = head.last;

endmodule

// ===== hdl/gzd_parser.sv =====
`timescale 1ns / 1ps
// ============================================================================
// gzd_parser
// Per-byte format detection, gzip header walk and result word generation.
// ============================================================================
module gzd_parser
    import gzd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 acc,
    input  logic [7:0]           in_byte,
    input  logic                 in_last,
    input  logic                 cfg_we,
    input  logic [LEN_W-1:0]     cfg_data,
    output res_t [RES_MAX-1:0]   res,
    output logic [1:0]           res_cnt
);

    typedef enum logic [2:0] {
        PH_FIXED,
        PH_XLEN_LO,
        PH_XLEN_HI,
        PH_EXTRA,
        PH_NAME,
        PH_COMMENT,
        PH_HCRC,
        PH_DATA
    } phase_t;

    logic [LEN_W-1:0] flen_reg, flen_next;
    logic [LEN_W-1:0] pos_reg, pos_next;
    logic [7:0]       held0_reg, held0_next;
    logic [7:0]       held1_reg, held1_next;
    logic [1:0]       fmt_reg, fmt_next;
    logic [7:0]       flag_reg, flag_next;
    phase_t           phase_reg, phase_next;
    logic [15:0]      skip_reg, skip_next;
    logic [LEN_W-1:0] cnt_reg, cnt_next;
    logic             short_reg, short_next;

    logic             fin;
    logic [LEN_W:0]   pos_inc;
    logic [LEN_W-1:0] remain;
    logic             trailer_ok;
    logic [7:0]       pb [RES_MAX];
    logic [1:0]       npass;
    logic [1:0]       fmt_cur;
    logic             ns_req;
    phase_t           ns_from;
    logic [15:0]      skip_tmp;
    logic [LEN_W:0]   cnt_sum;
    logic [LEN_W-1:0] cnt_new;
    logic [1:0]       nres;
    logic             err;
    logic             gz_hit;
    logic             zl_hit;
    logic [7:0]       zl_b1;

    always_comb
    begin
        pos_inc    = {1'b0, pos_reg} + {{LEN_W{1'b0}}, 1'b1};
        fin        = in_last || (pos_inc >= {1'b0, flen_reg});
        remain     = flen_reg - pos_reg;
        trailer_ok = (pos_reg < flen_reg) && (remain > TRAILER_LEN);
        zl_b1      = (pos_reg == LEN_W'(1)) ? in_byte : held1_reg;
        zl_hit     = (pos_reg != '0) && (held0_reg[3:0] == ZLIB_CM)
                     && mod31_zero({held0_reg, zl_b1});
        if (pos_reg == '0)
        begin
            zl_hit = 1'b0;
        end
        gz_hit     = (pos_reg == LEN_W'(2)) && (flen_reg >= GZ_MIN_LEN)
                     && (held0_reg == GZ_ID1) && (held1_reg == GZ_ID2)
                     && (in_byte == GZ_CM);

        flen_next  = cfg_we ? cfg_data : flen_reg;
        pos_next   = pos_reg;
        held0_next = held0_reg;
        held1_next = held1_reg;
        fmt_cur    = fmt_reg;
        flag_next  = flag_reg;
        phase_next = phase_reg;
        skip_next  = skip_reg;
        short_next = short_reg;
        npass      = 2'd0;
        pb[0]      = in_byte;
        pb[1]      = 8'd0;
        pb[2]      = 8'd0;
        ns_req     = 1'b0;
        ns_from    = PH_FIXED;
        skip_tmp   = 16'd0;

        if (acc)
        begin
            if ((pos_reg < LEN_W'(2)) && !fin)
            begin
                if (pos_reg[0])
                begin
                    held1_next = in_byte;
                end
                else
                begin
                    held0_next = in_byte;
                end
            end
            else if (pos_reg < LEN_W'(3))
            begin
                if (gz_hit)
                begin
                    fmt_cur    = FMT_GZIP;
                    phase_next = PH_FIXED;
                end
                else
                begin
                    fmt_cur = zl_hit ? FMT_ZLIB : FMT_RAW;
                    unique case (pos_reg[1:0])
                        2'd0:
                        begin
                            pb[0] = in_byte;
                            npass = 2'd1;
                        end
                        2'd1:
                        begin
                            pb[0] = held0_reg;
                            pb[1] = in_byte;
                            npass = 2'd2;
                        end
                        default:
                        begin
                            pb[0] = held0_reg;
                            pb[1] = held1_reg;
                            pb[2] = in_byte;
                            npass = 2'd3;
                        end
                    endcase
                end
            end
            else if (fmt_reg == FMT_GZIP)
            begin
                unique case (phase_reg)
                    PH_FIXED:
                    begin
                        if (pos_reg == GZ_FLG_POS)
                        begin
                            flag_next = in_byte;
                        end
                        if (pos_reg >= GZ_HDR_LAST)
                        begin
                            ns_req  = 1'b1;
                            ns_from = PH_FIXED;
                        end
                    end
                    PH_XLEN_LO:
                    begin
                        skip_next  = {8'd0, in_byte};
                        phase_next = PH_XLEN_HI;
                    end
                    PH_XLEN_HI:
                    begin
                        skip_tmp  = skip_reg | {in_byte, 8'd0};
                        skip_next = skip_tmp;
                        if (skip_tmp == 16'd0)
                        begin
                            ns_req  = 1'b1;
                            ns_from = PH_EXTRA;
                        end
                        else
                        begin
                            phase_next = PH_EXTRA;
                        end
                    end
                    PH_EXTRA, PH_HCRC:
                    begin
                        skip_tmp  = (skip_reg != 16'd0) ? skip_reg - 16'd1 : skip_reg;
                        skip_next = skip_tmp;
                        if (skip_tmp == 16'd0)
                        begin
                            ns_req  = 1'b1;
                            ns_from = phase_reg;
                        end
                    end
                    PH_NAME, PH_COMMENT:
                    begin
                        if (in_byte == 8'd0)
                        begin
                            ns_req  = 1'b1;
                            ns_from = phase_reg;
                        end
                    end
                    default:
                    begin
                        if (trailer_ok)
                        begin
                            pb[0] = in_byte;
                            npass = 2'd1;
                        end
                    end
                endcase
            end
            else
            begin
                pb[0] = in_byte;
                npass = 2'd1;
            end

            if (ns_req)
            begin
                priority if ((ns_from < PH_XLEN_LO) && ((flag_reg & FLG_FEXTRA) != 8'd0))
                begin
                    phase_next = PH_XLEN_LO;
                end
                else if ((ns_from < PH_NAME) && ((flag_reg & FLG_FNAME) != 8'd0))
                begin
                    phase_next = PH_NAME;
                end
                else if ((ns_from < PH_COMMENT) && ((flag_reg & FLG_FCMT) != 8'd0))
                begin
                    phase_next = PH_COMMENT;
                end
                else if ((ns_from < PH_HCRC) && ((flag_reg & FLG_FHCRC) != 8'd0))
                begin
                    phase_next = PH_HCRC;
                    skip_next  = HCRC_LEN;
                end
                else
                begin
                    phase_next = PH_DATA;
                    short_next = !trailer_ok;
                end
            end
        end

        cnt_sum = {1'b0, cnt_reg} + {{(LEN_W-1){1'b0}}, npass};
        cnt_new = cnt_sum[LEN_W] ? {LEN_W{1'b1}} : cnt_sum[LEN_W-1:0];
        err     = (fmt_cur == FMT_GZIP) && ((phase_next != PH_DATA) || short_next);
        nres    = (fin && (npass == 2'd0)) ? 2'd1 : npass;
        cnt_next = acc ? cnt_new : cnt_reg;
        fmt_next = acc ? fmt_cur : fmt_reg;

        if (acc && !((pos_reg < LEN_W'(2)) && !fin))
        begin
            if (!fin)
            begin
                pos_next = pos_inc[LEN_W] ? pos_reg : pos_inc[LEN_W-1:0];
            end
        end
        else if (acc)
        begin
            pos_next = pos_inc[LEN_W-1:0];
        end

        if (acc && fin)
        begin
            pos_next   = '0;
            held0_next = 8'd0;
            held1_next = 8'd0;
            fmt_next   = FMT_RAW;
            flag_next  = 8'd0;
            phase_next = PH_FIXED;
            skip_next  = 16'd0;
            cnt_next   = '0;
            short_next = 1'b0;
        end

        for (int i = 0; i < RES_MAX; i++)
        begin
            res[i].data  = pb[i];
            res[i].valid = 1'b1;
            res[i].fmt   = fmt_cur;
            res[i].plen  = '0;
            res[i].err   = 1'b0;
            res[i].last  = 1'b0;
        end
        if (fin)
        begin
            if (npass == 2'd0)
            begin
                res[0].data  = 8'd0;
                res[0].valid = 1'b0;
            end
            res[nres - 2'd1].plen = cnt_new;
            res[nres - 2'd1].err  = err;
            res[nres - 2'd1].last = 1'b1;
        end
        res_cnt = acc ? nres : 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flen_reg  <= LEN_W'(1);
            pos_reg   <= '0;
            held0_reg <= 8'd0;
            held1_reg <= 8'd0;
            fmt_reg   <= FMT_RAW;
            flag_reg  <= 8'd0;
            phase_reg <= PH_FIXED;
            skip_reg  <= 16'd0;
            cnt_reg   <= '0;
            short_reg <= 1'b0;
        end
        else
        begin
            flen_reg  <= flen_next;
            pos_reg   <= pos_next;
            held0_reg <= held0_next;
            held1_reg <= held1_next;
            fmt_reg   <= fmt_next;
            flag_reg  <= flag_next;
            phase_reg <= phase_next;
            skip_reg  <= skip_next;
            cnt_reg   <= cnt_next;
            short_reg <= short_next;
        end
    end

endmodule
